// File: rtl/core/uepd_pkg.sv
// Package: shared constants, types and helpers for the echo peak detector.
`timescale 1ns / 1ps
package uepd_pkg;

  localparam int BURST_LEN    = 8192;
  localparam int SAMPLE_SHIFT = 4;

  localparam int RAW_W    = 16;
  localparam int LEVEL_W  = 12;
  localparam int POS_W    = $clog2(BURST_LEN);
  localparam int IDX_W    = $clog2(BURST_LEN + 1);
  localparam int RESUME_W = POS_W + 1;
  localparam int MARGIN_W = 12;
  localparam int BLANK_W  = 13;
  localparam int WIDTH_W  = 13;
  localparam int DELAY_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX        = '1;
  localparam logic [MARGIN_W-1:0] ECHO_MARGIN_RST  = MARGIN_W'(100);
  localparam logic [BLANK_W-1:0]  BLANK_RST        = BLANK_W'(300);
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST    = WIDTH_W'(250);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ECHO_MARGIN     = 2'd0,
    CFG_BLANK_SAMPLES   = 2'd1,
    CFG_MAX_PULSE_WIDTH = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] echo_margin;
    logic [BLANK_W-1:0]  blank_samples;
    logic [WIDTH_W-1:0]  max_pulse_width;
  } cfg_regs_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pulse_start;
    logic [POS_W-1:0] pulse_end;
    logic [POS_W-1:0] peak_index;
  } burst_snap_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] shifted;
    shifted = raw >> SAMPLE_SHIFT;
    return shifted[LEVEL_W-1:0];
  endfunction

endpackage

// File: rtl/core/uepd_in_if.sv
// Interface: sample request channel.
`timescale 1ns / 1ps
interface uepd_in_if;
  logic                      valid;
  logic                      ready;
  logic [uepd_pkg::RAW_W-1:0] raw_sample;
  logic                      last_sample;

  modport source (output valid, output raw_sample, output last_sample, input ready);
  modport sink (input valid, input raw_sample, input last_sample, output ready);
endinterface

// File: rtl/core/uepd_out_if.sv
// Interface: echo result channel.
`timescale 1ns / 1ps
interface uepd_out_if;
  logic                        valid;
  logic                        ready;
  logic [uepd_pkg::DELAY_W-1:0] echo_delay;
  logic                        echo_found;

  modport source (output valid, output echo_delay, output echo_found, input ready);
  modport sink (input valid, input echo_delay, input echo_found, output ready);
endinterface

// File: rtl/core/uepd_cfg_if.sv
// Interface: configuration register write channel.
`timescale 1ns / 1ps
interface uepd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [uepd_pkg::CFG_IDX_W-1:0]  index;
  logic [uepd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/uepd_cfg_regs.sv
// Configuration registers: echo margin, blanking length, pulse width limit.
`timescale 1ns / 1ps
module uepd_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  uepd_cfg_if.sink            cfg_ch,
  output uepd_pkg::cfg_regs_t cfg
);

  uepd_pkg::cfg_regs_t cfg_r;
  uepd_pkg::cfg_regs_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (uepd_pkg::cfg_index_t'(cfg_ch.index))
        uepd_pkg::CFG_ECHO_MARGIN:
          cfg_nxt.echo_margin = cfg_ch.data[uepd_pkg::MARGIN_W-1:0];
        uepd_pkg::CFG_BLANK_SAMPLES:
          cfg_nxt.blank_samples = cfg_ch.data[uepd_pkg::BLANK_W-1:0];
        uepd_pkg::CFG_MAX_PULSE_WIDTH:
          cfg_nxt.max_pulse_width = cfg_ch.data[uepd_pkg::WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.echo_margin     <= uepd_pkg::ECHO_MARGIN_RST;
      cfg_r.blank_samples   <= uepd_pkg::BLANK_RST;
      cfg_r.max_pulse_width <= uepd_pkg::MAX_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/uepd_tracker.sv
// Sample register, running burst state (pulse, blanking, floor, peak) and burst snapshot.
`timescale 1ns / 1ps
module uepd_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  uepd_in_if.sink                in_ch,
  input  uepd_pkg::cfg_regs_t    cfg,
  output uepd_pkg::burst_snap_t  snap,
  input  logic                   snap_take
);

  localparam int POS_W    = uepd_pkg::POS_W;
  localparam int IDX_W    = uepd_pkg::IDX_W;
  localparam int RESUME_W = uepd_pkg::RESUME_W;
  localparam int LEVEL_W  = uepd_pkg::LEVEL_W;

  logic                 a_valid_r;
  logic [LEVEL_W-1:0]   a_level_r;
  logic                 a_last_r;
  logic                 a_adv;

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [POS_W-1:0]     start_r, start_nxt;
  logic [POS_W-1:0]     end_r, end_nxt;
  logic [RESUME_W-1:0]  resume_r, resume_nxt;
  logic [LEVEL_W-1:0]   floor_r, floor_nxt;
  logic [POS_W-1:0]     peak_idx_r, peak_idx_nxt;
  logic [LEVEL_W-1:0]   peak_lvl_r, peak_lvl_nxt;
  logic                 done_r, done_nxt;

  uepd_pkg::burst_snap_t snap_r, snap_nxt;

  logic [POS_W-1:0]     pos;
  logic [LEVEL_W:0]     floor_hi;
  logic [LEVEL_W:0]     level_lo;

  // Hold a final sample while the snapshot stage is still full.
  assign a_adv       = !a_last_r || !snap_r.valid || snap_take;
  assign in_ch.ready = !a_valid_r || a_adv;
  assign snap        = snap_r;

  assign pos      = idx_r[POS_W-1:0];
  assign floor_hi = {1'b0, floor_r} + {1'b0, cfg.echo_margin};
  assign level_lo = {1'b0, a_level_r} + {1'b0, cfg.echo_margin};

  always_comb begin
    idx_nxt      = idx_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    resume_nxt   = resume_r;
    floor_nxt    = floor_r;
    peak_idx_nxt = peak_idx_r;
    peak_lvl_nxt = peak_lvl_r;
    done_nxt     = done_r;
    snap_nxt     = snap_r;
    if (snap_take) begin
      snap_nxt.valid = 1'b0;
    end
    if (a_valid_r && a_adv) begin
      if (idx_r < IDX_W'(uepd_pkg::BURST_LEN)) begin
        idx_nxt = idx_r + IDX_W'(1);
        if (!done_r && RESUME_W'(pos) >= resume_r) begin
          if (start_r == '0 && a_level_r == uepd_pkg::LEVEL_MAX) begin
            start_nxt = pos;
          end else if (start_r != '0 && end_r == '0 && a_level_r != uepd_pkg::LEVEL_MAX) begin
            end_nxt    = pos - POS_W'(1);
            resume_nxt = RESUME_W'(pos) + RESUME_W'(cfg.blank_samples) + RESUME_W'(1);
          end
          if (start_r != '0 && end_r != '0) begin
            if (peak_idx_r == '0 && a_level_r < floor_r) begin
              floor_nxt = a_level_r;
            end else if ({1'b0, a_level_r} > floor_hi) begin
              peak_idx_nxt = pos;
              peak_lvl_nxt = a_level_r;
              floor_nxt    = a_level_r - cfg.echo_margin;
            end else if (peak_idx_r != '0 && level_lo < {1'b0, peak_lvl_r}) begin
              done_nxt = 1'b1;
            end
          end
        end
      end
      if (a_last_r) begin
        snap_nxt.valid       = 1'b1;
        snap_nxt.pulse_start = start_nxt;
        snap_nxt.pulse_end   = end_nxt;
        snap_nxt.peak_index  = peak_idx_nxt;
        idx_nxt      = '0;
        start_nxt    = '0;
        end_nxt      = '0;
        resume_nxt   = '0;
        floor_nxt    = uepd_pkg::LEVEL_MAX;
        peak_idx_nxt = '0;
        peak_lvl_nxt = '0;
        done_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      idx_r      <= '0;
      start_r    <= '0;
      end_r      <= '0;
      resume_r   <= '0;
      floor_r    <= uepd_pkg::LEVEL_MAX;
      peak_idx_r <= '0;
      peak_lvl_r <= '0;
      done_r     <= 1'b0;
      snap_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        a_valid_r <= in_ch.valid;
      end
      idx_r      <= idx_nxt;
      start_r    <= start_nxt;
      end_r      <= end_nxt;
      resume_r   <= resume_nxt;
      floor_r    <= floor_nxt;
      peak_idx_r <= peak_idx_nxt;
      peak_lvl_r <= peak_lvl_nxt;
      done_r     <= done_nxt;
      snap_r     <= snap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_level_r <= uepd_pkg::level_of(in_ch.raw_sample);
      a_last_r  <= in_ch.last_sample;
    end
  end

endmodule

// File: rtl/core/uepd_result.sv
// Echo delay from the burst snapshot into the output register.
`timescale 1ns / 1ps
module uepd_result (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uepd_pkg::burst_snap_t snap,
  input  uepd_pkg::cfg_regs_t   cfg,
  output logic                  snap_take,
  uepd_out_if.source            out_ch
);

  localparam int POS_W   = uepd_pkg::POS_W;
  localparam int DELAY_W = uepd_pkg::DELAY_W;

  logic               out_valid_r;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic               found_r, found_nxt;

  logic [POS_W-1:0]   width;
  logic               ok;

  assign snap_take = snap.valid && (!out_valid_r || out_ch.ready);

  assign width = snap.pulse_end - snap.pulse_start;
  assign ok = snap.peak_index != '0 && snap.pulse_end != '0 &&
              snap.peak_index > snap.pulse_end &&
              snap.pulse_end >= snap.pulse_start &&
              {1'b0, width} <= {1'b0, cfg.max_pulse_width};

  always_comb begin
    delay_nxt = '0;
    if (ok) begin
      delay_nxt = DELAY_W'(snap.peak_index - snap.pulse_end + (width >> 1));
    end
    found_nxt = delay_nxt != '0;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.echo_delay = delay_r;
  assign out_ch.echo_found = found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      delay_r <= delay_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

// File: rtl/core/ultrasonic_echo_peak_detector_top.sv
// Top level: ultrasonic echo peak detector.
//
// in_ch takes one converter word per request; the upper 12 bits are the level.
// last_sample marks the final word of a burst. out_ch gives one request per
// burst: echo_delay in samples from the transmit pulse midpoint, 0 when no
// valid echo was seen, and echo_found when the delay is nonzero.
// cfg_ch writes echo_margin (index 0), blank_samples (1) and max_pulse_width (2);
// the user must write them only while the block is idle, as the block does not
// enforce this. It is always ready and other indexes are dropped. Throughput:
// one sample per cycle into the running burst registers behind the sample
// register unless a final sample is held; results pass snapshot and output stages.
// Reset restores the register defaults (100, 300, 250) and clears the burst.
// When out_ch stalls the result holds in the output register and a second
// burst result holds in the snapshot stage; samples keep flowing until a final
// sample meets a full snapshot stage, which holds in_ch until the output drains.
`timescale 1ns / 1ps
module ultrasonic_echo_peak_detector_top (
  input  logic       clk,
  input  logic       rst_n,
  uepd_in_if.sink    in_ch,
  uepd_out_if.source out_ch,
  uepd_cfg_if.sink   cfg_ch
);

  uepd_pkg::cfg_regs_t   cfg;
  uepd_pkg::burst_snap_t snap;
  logic                  snap_take;

  uepd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uepd_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .snap      (snap),
    .snap_take (snap_take)
  );

  uepd_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap      (snap),
    .cfg       (cfg),
    .snap_take (snap_take),
    .out_ch    (out_ch)
  );

endmodule
